[rtl/sem_pkg.sv]
// Shared types and fixed field widths for the Sobel edge magnitude unit.
`timescale 1ns / 1ps
`default_nettype none

package sem_pkg;

    localparam int PIX_IN_BITS = 8;
    localparam int IW_BITS     = 11;
    localparam int IH_BITS     = 13;
    localparam int ROW_BITS    = 12;
    localparam int COL_BITS    = 10;
    localparam int MAG_BITS    = 11;
    localparam int APB_BITS    = 32;
    localparam int ADDR_BITS   = 3;

    // Register index, taken from the word part of the byte address
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Status of the iterative square root unit
    typedef struct packed {
        logic busy;
        logic ready;
    } sqrt_status_t;

endpackage

`default_nettype wire

[rtl/sem_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/sem_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sem_isqrt #(
    parameter int ROOT_BITS = 11
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [2*ROOT_BITS-1:0]     radicand,
    output sem_pkg::sqrt_status_t           status,
    output logic      [ROOT_BITS-1:0]       root
);

    import sem_pkg::*;

    localparam int SqBits  = 2 * ROOT_BITS;
    localparam int RemBits = ROOT_BITS + 3;
    localparam int CntBits = $clog2(ROOT_BITS + 1);

    logic [SqBits-1:0]    rad_reg;
    logic [RemBits-1:0]   rem_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [CntBits-1:0]   cnt_reg;
    logic                 busy_reg;
    logic                 ready_reg;

    logic [RemBits-1:0]   rem_shift;
    logic [RemBits-1:0]   trial;
    logic                 fits;

    // Bring down the next two radicand bits and try the next root bit
    assign rem_shift = {rem_reg[RemBits-3:0], rad_reg[SqBits-1 -: 2]};
    assign trial     = RemBits'({root_reg, 2'b01});
    assign fits      = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            ready_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            ready_reg <= 1'b0;
            cnt_reg   <= CntBits'(ROOT_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CntBits'(1);
            if (cnt_reg == CntBits'(1))
            begin
                busy_reg  <= 1'b0;
                ready_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SqBits-3:0], 2'b00};
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[ROOT_BITS-2:0], fits};
        end
    end

    assign status.busy  = busy_reg;
    assign status.ready = ready_reg;
    assign root         = root_reg;

endmodule

`default_nettype wire

[rtl/sobel_edge_magnitude_unit.sv]
// Top level of the streaming 3x3 Sobel gradient magnitude unit.
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  -----------------------------------------
//  pixel     in         pixel_valid/pixel_stall   pixel_value, frame_start
//  result    out        result_valid/result_stall center_row, center_col, magnitude,
//                                                 frame_last
//  config    in         APB psel/penable/pready   paddr, pwdata, prdata
//
// A border pixel request passes through the line store read, then the write back.
// An interior pixel request steps through read, gradient, squares, root start, then
// the square root loop producing one root bit per cycle.
// The result sits in an output register; the next pixel request is taken while it waits.
// Reset clears positions, window and control; the line store is not cleared and needs
// no clearing pass. A stalled result holds nothing until the next interior root is done;
// that one then waits in the root state and holds pixel_stall high until the slot frees.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_magnitude_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sem_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [sem_pkg::APB_BITS-1:0]    pwdata,
    output logic      [sem_pkg::APB_BITS-1:0]    prdata,
    output logic                                 pready,
    // pixel requests
    input  wire logic                            pixel_valid,
    output logic                                 pixel_stall,
    input  wire logic [sem_pkg::PIX_IN_BITS-1:0] pixel_value,
    input  wire logic                            frame_start,
    // result requests
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic      [sem_pkg::ROW_BITS-1:0]    center_row,
    output logic      [sem_pkg::COL_BITS-1:0]    center_col,
    output logic      [sem_pkg::MAG_BITS-1:0]    magnitude,
    output logic                                 frame_last
);

    import sem_pkg::*;

    localparam int ColBits  = $clog2(MAX_WIDTH);
    localparam int CmpBits  = ((ColBits > IW_BITS) ? ColBits : IW_BITS) + 1;
    localparam int InBits   = (PIXEL_BITS < PIX_IN_BITS) ? PIXEL_BITS : PIX_IN_BITS;
    localparam int RootBits = PIXEL_BITS + 3;
    localparam int GBits    = PIXEL_BITS + 3;
    localparam int SqBits   = 2 * RootBits;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_GRAD,
        S_SQUARE,
        S_START,
        S_ROOT
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [IW_BITS-1:0] width_reg;
    logic [IH_BITS-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IW_BITS'(640);
            height_reg <= IH_BITS'(480);
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (cfg_reg_t'(paddr[2]))
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[IW_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[IH_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_reg_t'(paddr[2]))
            REG_IMAGE_WIDTH:  prdata = APB_BITS'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_BITS'(height_reg);
        endcase
    end

    assign pready = 1'b1;

    // Saturate the frame size to what the line store and row counter allow
    logic [CmpBits-1:0] width_ext;
    logic [CmpBits-1:0] eff_w;
    logic [IH_BITS-1:0] eff_h;

    assign width_ext = CmpBits'(width_reg);

    always_comb
    begin
        if (width_ext < CmpBits'(3))
            eff_w = CmpBits'(3);
        else if (width_ext > CmpBits'(MAX_WIDTH))
            eff_w = CmpBits'(MAX_WIDTH);
        else
            eff_w = width_ext;

        if (height_reg < IH_BITS'(3))
            eff_h = IH_BITS'(3);
        else if (height_reg > IH_BITS'(4096))
            eff_h = IH_BITS'(4096);
        else
            eff_h = height_reg;
    end

    // ------------------------------------------------------------------
    // Position tracking for an accepted pixel
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [ColBits-1:0]     col_reg;
    logic [ROW_BITS-1:0]    row_reg;

    logic                   pixel_accept;
    logic [ColBits-1:0]     col_start;
    logic [ROW_BITS-1:0]    row_start;
    logic [CmpBits-1:0]     cur_col_ext;
    logic [ColBits-1:0]     cur_col;
    logic [IH_BITS-1:0]     row_bumped;
    logic [ROW_BITS-1:0]    cur_row;
    logic [CmpBits-1:0]     col_plus;
    logic [IH_BITS-1:0]     row_plus;
    logic [ColBits-1:0]     col_next;
    logic [ROW_BITS-1:0]    row_next;
    logic [CmpBits-1:0]     col_minus;
    logic                   emit;
    logic                   is_last;
    logic                   row_wrap;

    assign pixel_stall  = (state_reg != S_IDLE);
    assign pixel_accept = pixel_valid && !pixel_stall;

    always_comb
    begin
        // frame start restarts the raster
        col_start = frame_start ? '0 : col_reg;
        row_start = frame_start ? '0 : row_reg;

        // width lowered mid-row: wrap the column and advance the row first
        row_wrap   = (CmpBits'(col_start) >= eff_w);
        cur_col    = row_wrap ? '0 : col_start;
        row_bumped = IH_BITS'(row_start) + (row_wrap ? IH_BITS'(1) : IH_BITS'(0));
        cur_row    = (row_bumped >= eff_h) ? '0 : row_bumped[ROW_BITS-1:0];

        cur_col_ext = CmpBits'(cur_col);
        col_plus    = cur_col_ext + CmpBits'(1);
        row_plus    = IH_BITS'(cur_row) + IH_BITS'(1);

        if (col_plus >= eff_w)
        begin
            col_next = '0;
            row_next = (row_plus >= eff_h) ? '0 : row_plus[ROW_BITS-1:0];
        end
        else
        begin
            col_next = col_plus[ColBits-1:0];
            row_next = cur_row;
        end

        col_minus = cur_col_ext - CmpBits'(1);
        emit      = (cur_row >= ROW_BITS'(2)) && (cur_col_ext >= CmpBits'(2));
        is_last   = (IH_BITS'(cur_row) == eff_h - IH_BITS'(1))
                    && (cur_col_ext == eff_w - CmpBits'(1));
    end

    // ------------------------------------------------------------------
    // Line store: one entry per column holding the two rows above
    // ------------------------------------------------------------------
    logic                      ram_wr_en;
    logic                      ram_rd_en;
    logic [2*PIXEL_BITS-1:0]   ram_rd_data;
    logic [2*PIXEL_BITS-1:0]   ram_wr_data;
    logic [ColBits-1:0]        addr_reg;
    logic [PIXEL_BITS-1:0]     pix_reg;
    logic [PIXEL_BITS-1:0]     line_top;
    logic [PIXEL_BITS-1:0]     line_mid;

    assign ram_rd_en   = pixel_accept;
    assign ram_wr_en   = (state_reg == S_READ);
    assign line_top    = ram_rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
    assign line_mid    = ram_rd_data[PIXEL_BITS-1:0];
    // push the rows down: middle becomes top, current pixel becomes middle
    assign ram_wr_data = {line_mid, pix_reg};

    sem_ram #(
        .WIDTH (2 * PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (addr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (cur_col),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Gradients and squares
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0]    win_reg [3][3];
    logic signed [GBits-1:0]  w00, w01, w02, w10, w12, w20, w21, w22;
    logic signed [GBits-1:0]  gx_next, gy_next;
    logic signed [GBits-1:0]  gx_reg, gy_reg;
    logic signed [2*GBits-1:0] gx_sq, gy_sq;
    logic [SqBits-1:0]        sum_reg;

    always_comb
    begin
        w00 = $signed({3'b000, win_reg[0][0]});
        w01 = $signed({3'b000, win_reg[0][1]});
        w02 = $signed({3'b000, win_reg[0][2]});
        w10 = $signed({3'b000, win_reg[1][0]});
        w12 = $signed({3'b000, win_reg[1][2]});
        w20 = $signed({3'b000, win_reg[2][0]});
        w21 = $signed({3'b000, win_reg[2][1]});
        w22 = $signed({3'b000, win_reg[2][2]});

        gx_next = (w02 - w00) + ((w12 - w10) <<< 1) + (w22 - w20);
        gy_next = (w20 + (w21 <<< 1) + w22) - (w00 + (w01 <<< 1) + w02);

        gx_sq = gx_reg * gx_reg;
        gy_sq = gy_reg * gy_reg;
    end

    // ------------------------------------------------------------------
    // Square root
    // ------------------------------------------------------------------
    sqrt_status_t          sq_status;
    logic [RootBits-1:0]   sq_root;
    logic                  sq_start;

    assign sq_start = (state_reg == S_START);

    sem_isqrt #(
        .ROOT_BITS (RootBits)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sum_reg),
        .status   (sq_status),
        .root     (sq_root)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic                 emit_reg;
    logic                 last_reg;
    logic [ROW_BITS-1:0]  crow_reg;
    logic [COL_BITS-1:0]  ccol_reg;
    logic                 out_valid_reg;
    logic                 out_free;
    logic                 out_load;

    assign out_free = !out_valid_reg || !result_stall;
    assign out_load = (state_reg == S_ROOT) && sq_status.ready && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (pixel_accept) state_next = S_READ;
            S_READ:   state_next = emit_reg ? S_GRAD : S_IDLE;
            S_GRAD:   state_next = S_SQUARE;
            S_SQUARE: state_next = S_START;
            S_START:  state_next = S_ROOT;
            S_ROOT:   if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // state, positions, window and the result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;

            if (pixel_accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                emit_reg <= emit;
            end

            // slide the window one column and insert the fresh column
            if (state_reg == S_READ)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= line_top;
                win_reg[1][2] <= line_mid;
                win_reg[2][2] <= pix_reg;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            addr_reg <= cur_col;
            pix_reg  <= PIXEL_BITS'(pixel_value[InBits-1:0]);
            crow_reg <= cur_row - ROW_BITS'(1);
            ccol_reg <= col_minus[COL_BITS-1:0];
            last_reg <= is_last;
        end
        if (state_reg == S_GRAD)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
        if (state_reg == S_SQUARE)
        begin
            sum_reg <= $unsigned(gx_sq) + $unsigned(gy_sq);
        end
        if (out_load)
        begin
            center_row <= crow_reg;
            center_col <= ccol_reg;
            magnitude  <= MAG_BITS'(sq_root);
            frame_last <= last_reg;
        end
    end

    assign result_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the root unit only runs while the sequencer waits for it
    a_root_busy_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        sq_status.busy |-> (state_reg == S_ROOT))
        else $error("square root busy outside the root state");

    // a line store read never coincides with its write back
    a_ram_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> !ram_rd_en)
        else $error("line store read and write in the same cycle");

    // a new result only follows a finished square root
    a_result_after_root: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_ROOT && sq_status.ready))
        else $error("result raised without a finished square root");

    // an interior pixel always goes from its read through gradient and squares to the root start
    a_interior_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && emit_reg) |=> ##2 (state_reg == S_START))
        else $error("interior pixel left the gradient path");

endmodule

`default_nettype wire

[verif/sobel_edge_magnitude_unit_tb.sv]
// Self-checking testbench for the streaming Sobel edge magnitude unit.
`timescale 1ns / 1ps

module sobel_edge_magnitude_unit_tb;

    import sem_pkg::*;

    // Saturation bounds of the two geometry registers
    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 4096;

    // Watchdog bound for the whole run
    localparam int CYCLE_LIMIT = 1_000_000;
    // Longest wait for outstanding results before declaring them lost
    localparam int SETTLE_LIMIT = 5000;
    // Gap that lets the pipeline empty before a register write
    localparam int PIPE_GAP = 40;
    // Pixels sent into the first row of the full-width frame
    localparam int WIDE_ITEMS = 64;
    // Pixel budget of one random phase, and the longest frame sent in one go
    localparam int PHASE_ITEMS = 70;
    localparam int FRAME_CAP   = 120;

    // One result as the block reports it
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic [MAG_BITS-1:0] mag;
        logic                last;
    } edge_res_t;

    // Directed table: either a register write or one pixel request
    typedef enum logic {
        ROW_WRITE,
        ROW_PIXEL
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        cfg_reg_t               sel;
        logic [APB_BITS-1:0]    wdata;
        logic [PIX_IN_BITS-1:0] pix;
        logic                   fs;
        bit                     known;
        edge_res_t              want;
    } stim_row_t;

    // Shapes of the random frames
    typedef enum {
        FRAME_WHOLE,   // frame_start, then exactly one frame of pixels
        FRAME_CUT,     // frame_start, then the frame abandoned part-way
        FRAME_CARRY    // a whole frame's worth, no frame_start unless restarting: the raster wraps
    } frame_kind_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   psel         = 1'b0;
    logic                   penable      = 1'b0;
    logic                   pwrite       = 1'b0;
    logic [ADDR_BITS-1:0]   paddr        = '0;
    logic [APB_BITS-1:0]    pwdata       = '0;
    logic [APB_BITS-1:0]    prdata;
    logic                   pready;
    logic                   pixel_valid  = 1'b0;
    logic                   pixel_stall;
    logic [PIX_IN_BITS-1:0] pixel_value  = '0;
    logic                   frame_start  = 1'b0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic [ROW_BITS-1:0]    center_row;
    logic [COL_BITS-1:0]    center_col;
    logic [MAG_BITS-1:0]    magnitude;
    logic                   frame_last;

    sobel_edge_magnitude_unit dut (.*);

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the geometry registers, the two
    // previous image rows, the 3x3 window and the raster position.
    // ------------------------------------------------------------------
    logic [IW_BITS-1:0]     width_reg  = 11'd640;
    logic [IH_BITS-1:0]     height_reg = 13'd480;
    logic [PIX_IN_BITS-1:0] prev2_row [MAX_COLS] = '{default: '0};
    logic [PIX_IN_BITS-1:0] prev1_row [MAX_COLS] = '{default: '0};
    logic [PIX_IN_BITS-1:0] win [3][3] = '{default: '{default: '0}};
    int                     at_col = 0;
    int                     at_row = 0;

    edge_res_t pending_results [$];

    int idle_pct     = 0;
    int stall_pct    = 0;
    int mismatches   = 0;
    int pixels_sent  = 0;
    int results_seen = 0;
    int frames_sent  = 0;
    int cycle_count  = 0;

    // Idling mix per phase: none, sender idle, receiver stalling, both lightly
    int idle_mix  [4] = '{0, 63, 0, 16};
    int stall_mix [4] = '{0, 0, 63, 16};

    stim_row_t directed_rows [$];

    function automatic int eff_width();
        int w;
        w = int'(width_reg);
        if (w < 3) w = 3;
        if (w > MAX_COLS) w = MAX_COLS;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = int'(height_reg);
        if (h < 3) h = 3;
        if (h > MAX_ROWS) h = MAX_ROWS;
        return h;
    endfunction

    // Advance the raster by one pixel and work out the result it causes, if any.
    task automatic predict_magnitude(input logic [PIX_IN_BITS-1:0] pix, input logic fs,
                                     output bit hit, output edge_res_t res);
        int w, h, c, r, i, b, gx, gy, sq, root, trial;
        logic [PIX_IN_BITS-1:0] above, middle;
        w = eff_width();
        h = eff_height();
        if (fs)
        begin
            at_col = 0;
            at_row = 0;
        end
        // Width lowered mid-row: wrap before the pixel is placed
        if (at_col >= w)
        begin
            at_col = 0;
            at_row++;
        end
        // Past the last row without frame_start: start over at the top
        if (at_row >= h) at_row = 0;
        c = at_col;
        r = at_row;

        above  = prev2_row[c];
        middle = prev1_row[c];
        prev2_row[c] = middle;
        prev1_row[c] = pix;

        for (i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = above;
        win[1][2] = middle;
        win[2][2] = pix;

        if (c + 1 >= w)
        begin
            at_col = 0;
            at_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            at_col = c + 1;
        end

        hit = (r >= 2) && (c >= 2);
        res = '0;
        if (hit)
        begin
            gx = (int'(win[0][2]) - int'(win[0][0]))
               + 2 * (int'(win[1][2]) - int'(win[1][0]))
               + (int'(win[2][2]) - int'(win[2][0]));
            gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
               - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
            sq = gx * gx + gy * gy;
            // Integer square root, one bit at a time from the top
            root = 0;
            for (b = MAG_BITS - 1; b >= 0; b--)
            begin
                trial = root | (1 << b);
                if (trial * trial <= sq) root = trial;
            end
            res.row  = ROW_BITS'(r - 1);
            res.col  = COL_BITS'(c - 1);
            res.mag  = MAG_BITS'(root);
            res.last = (r == h - 1) && (c == w - 1);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Drive one pixel request at the falling edge, hold it until taken, then predict.
    task automatic send_pixel(input logic [PIX_IN_BITS-1:0] pix, input logic fs,
                              input bit known, input edge_res_t known_res);
        bit        hit;
        edge_res_t res;
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_value <= pix;
        frame_start <= fs;
        do @(posedge clk); while (pixel_stall);
        pixels_sent++;
        predict_magnitude(pix, fs, hit, res);
        if (hit) pending_results.push_back(known ? known_res : res);
    endtask

    // Two-phase register write; the predictor copy changes at the access edge.
    task automatic apb_write(input cfg_reg_t sel, input logic [APB_BITS-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (sel == REG_IMAGE_WIDTH)
            width_reg = value[IW_BITS-1:0];
        else
            height_reg = value[IH_BITS-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline empty.
    task automatic settle_results();
        int spins;
        spins = 0;
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (pending_results.size() != 0 && spins < SETTLE_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        if (pending_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));
            pending_results.delete();
        end
        repeat (PIPE_GAP) @(posedge clk);
    endtask

    function automatic logic [PIX_IN_BITS-1:0] pick_pixel();
        // Bias towards black and white so strong edges turn up often
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return PIX_IN_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic stim_row_t write_row(input cfg_reg_t sel,
                                            input logic [APB_BITS-1:0] value);
        stim_row_t t;
        t.kind  = ROW_WRITE;
        t.sel   = sel;
        t.wdata = value;
        t.pix   = '0;
        t.fs    = 1'b0;
        t.known = 1'b0;
        t.want  = '0;
        return t;
    endfunction

    function automatic stim_row_t pixel_row(input logic [PIX_IN_BITS-1:0] pix,
                                            input logic fs);
        stim_row_t t;
        t.kind  = ROW_PIXEL;
        t.sel   = REG_IMAGE_WIDTH;
        t.wdata = '0;
        t.pix   = pix;
        t.fs    = fs;
        t.known = 1'b0;
        t.want  = '0;
        return t;
    endfunction

    function automatic stim_row_t known_row(input logic [PIX_IN_BITS-1:0] pix,
                                            input int row, input int col, input int mag,
                                            input logic last);
        stim_row_t t;
        t = pixel_row(pix, 1'b0);
        t.known = 1'b1;
        t.want  = '{row: ROW_BITS'(row), col: COL_BITS'(col), mag: MAG_BITS'(mag),
                    last: last};
        return t;
    endfunction

    // Receiver stalls at random, changing only at the falling edge
    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Compare each accepted result field by field with the oldest expectation
    always @(posedge clk)
    begin : result_check
        edge_res_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result row %0d col %0d mag %0d",
                                          center_row, center_col, magnitude));
            end
            else
            begin
                want = pending_results.pop_front();
                if (center_row !== want.row)
                    report_mismatch($sformatf("center_row %0d, want %0d",
                                              center_row, want.row));
                if (center_col !== want.col)
                    report_mismatch($sformatf("center_col %0d, want %0d (row %0d)",
                                              center_col, want.col, want.row));
                if (magnitude !== want.mag)
                    report_mismatch($sformatf("magnitude %0d, want %0d at (%0d,%0d)",
                                              magnitude, want.mag, want.row, want.col));
                if (frame_last !== want.last)
                    report_mismatch($sformatf("frame_last %0b, want %0b at (%0d,%0d)",
                                              frame_last, want.last, want.row, want.col));
            end
        end
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          phase, k, n, len, w_raw, h_raw, old_w, phase_items;
        bit          restart;
        frame_kind_t kind;
        logic        fs_now;

        // Hold reset, then release it away from the rising edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --------------------------------------------------------------
        // Directed part.
        // Frame A: 3x3 (both registers written below the minimum, so they
        //   saturate to 3), dark left column, white right column: strongest
        //   horizontal gradient, a single result that also ends the frame.
        // Frame B: all white, no frame_start: the raster wraps into a new
        //   frame by itself; flat image gives zero magnitude.
        // Frame C: width 5 for four pixels, then width lowered to 3 while
        //   the column is past the new row end, so the row advances early.
        // --------------------------------------------------------------
        directed_rows = {
            write_row(REG_IMAGE_WIDTH, 32'd0),
            write_row(REG_IMAGE_HEIGHT, 32'd2),
            pixel_row(8'd0, 1'b1), pixel_row(8'd0, 1'b0), pixel_row(8'd255, 1'b0),
            pixel_row(8'd0, 1'b0), pixel_row(8'd0, 1'b0), pixel_row(8'd255, 1'b0),
            pixel_row(8'd0, 1'b0), pixel_row(8'd0, 1'b0),
            known_row(8'd255, 1, 1, 1020, 1'b1),
            pixel_row(8'd255, 1'b0), pixel_row(8'd255, 1'b0), pixel_row(8'd255, 1'b0),
            pixel_row(8'd255, 1'b0), pixel_row(8'd255, 1'b0), pixel_row(8'd255, 1'b0),
            pixel_row(8'd255, 1'b0), pixel_row(8'd255, 1'b0),
            known_row(8'd255, 1, 1, 0, 1'b1),
            write_row(REG_IMAGE_WIDTH, 32'd5),
            pixel_row(8'd10, 1'b1), pixel_row(8'd200, 1'b0), pixel_row(8'd30, 1'b0),
            pixel_row(8'd99, 1'b0),
            write_row(REG_IMAGE_WIDTH, 32'd3),
            pixel_row(8'd255, 1'b0), pixel_row(8'd0, 1'b0), pixel_row(8'd128, 1'b0),
            pixel_row(8'd1, 1'b0), pixel_row(8'd2, 1'b0), pixel_row(8'd254, 1'b0)
        };

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                settle_results();
                apb_write(directed_rows[i].sel, directed_rows[i].wdata);
            end
            else
            begin
                send_pixel(directed_rows[i].pix, directed_rows[i].fs,
                           directed_rows[i].known, directed_rows[i].want);
            end
        end
        frames_sent += 3;

        // --------------------------------------------------------------
        // The opening of a frame at full width (written above range, so it
        // saturates to the maximum) and minimum height: the first row runs
        // on past every smaller width without wrapping, so no result is due.
        // Junk in the upper write bits must be dropped.
        // --------------------------------------------------------------
        settle_results();
        apb_write(REG_IMAGE_WIDTH, ($urandom() & 32'hFFFF_F800) | 32'h7FF);
        apb_write(REG_IMAGE_HEIGHT, 32'd3);
        for (k = 0; k < WIDE_ITEMS; k++)
            send_pixel(pick_pixel(), k == 0, 1'b0, '0);
        frames_sent++;

        // --------------------------------------------------------------
        // Random phases: fresh geometry each phase, idling mix cycling
        // through none / sender / receiver / both. Mostly whole frames with
        // random content, the rest cut short or carried on without
        // frame_start, with the odd stray frame_start mid-frame.
        // --------------------------------------------------------------
        for (phase = 0; phase < 8; phase++)
        begin
            settle_results();
            idle_pct  = idle_mix[phase % 4];
            stall_pct = stall_mix[phase % 4];

            case ($urandom_range(0, 9))
                0:       w_raw = $urandom_range(0, 2);
                1:       w_raw = $urandom_range(13, 40);
                default: w_raw = $urandom_range(3, 12);
            endcase
            if (phase == 3)
                h_raw = 8191;
            else if (phase == 5)
                h_raw = MAX_ROWS;
            else if ($urandom_range(0, 9) == 0)
                h_raw = $urandom_range(0, 2);
            else
                h_raw = $urandom_range(3, 8);

            // A wider row would read line store columns never filled: restart the frame
            old_w = eff_width();
            apb_write(REG_IMAGE_WIDTH, ($urandom() & 32'hFFFF_F800) | w_raw);
            apb_write(REG_IMAGE_HEIGHT, ($urandom() & 32'hFFFF_E000) | h_raw);
            restart = (eff_width() > old_w);

            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                case ($urandom_range(0, 9))
                    7, 8:    kind = FRAME_CUT;
                    9:       kind = FRAME_CARRY;
                    default: kind = FRAME_WHOLE;
                endcase
                n = eff_width() * eff_height();
                // Large frames would eat the whole budget: cut them
                if (n > FRAME_CAP) kind = FRAME_CUT;
                if (kind == FRAME_CUT)
                    len = $urandom_range(1, (n > FRAME_CAP) ? FRAME_CAP : n - 1);
                else
                    len = n;

                for (k = 0; k < len; k++)
                begin
                    fs_now = (k == 0 && (kind != FRAME_CARRY || restart))
                             || ($urandom_range(0, 199) == 0);
                    restart = 1'b0;
                    send_pixel(pick_pixel(), fs_now, 1'b0, '0);
                end
                phase_items += len;
                frames_sent++;
            end
        end

        // Drain, then close the run
        settle_results();

        $display("covered %0d pixel requests in %0d frames, %0d results checked",
                 pixels_sent, frames_sent, results_seen);
        $display("widths 3 to 1024, heights 3 to 4096, four idling mixes, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sobel_edge_magnitude_unit.f]
rtl/sem_pkg.sv
rtl/sem_ram.sv
rtl/sem_isqrt.sv
rtl/sobel_edge_magnitude_unit.sv
verif/sobel_edge_magnitude_unit_tb.sv
